// ----- hdl/mexp_pkg.sv -----
package mexp_pkg;

  localparam int MOD_WIDTH = 32;
  localparam int EXP_WIDTH = 63;

  localparam int BASE_IN_WIDTH = 63;
  localparam int EXP_IN_WIDTH  = 63;
  localparam int MOD_IN_WIDTH  = 32;
  localparam int OUT_WIDTH     = 32;

  localparam int OP_WIDTH  = BASE_IN_WIDTH;
  localparam int CNT_WIDTH = $clog2(OP_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [MOD_WIDTH-1:0] mult;
    logic [OP_WIDTH-1:0]  bits;
    logic [CNT_WIDTH-1:0] nbits;
  } mm_req_t;

endpackage

// ----- hdl/mexp_mulred.sv -----
module mexp_mulred (
  input  logic                     clk,
  input  logic                     rst,
  input  mexp_pkg::mm_req_t        req,
  input  logic [mexp_pkg::MOD_WIDTH-1:0] modulus,
  output logic                     done,
  output logic [mexp_pkg::MOD_WIDTH-1:0] result
);
  import mexp_pkg::*;

  logic                 busy;
  logic [CNT_WIDTH-1:0] cnt;
  logic [OP_WIDTH-1:0]  sh;
  logic [MOD_WIDTH-1:0] mult;
  logic [MOD_WIDTH-1:0] r;
  logic [MOD_WIDTH-1:0] r_next;
  logic [MOD_WIDTH+1:0] t;
  logic [MOD_WIDTH+1:0] m1;
  logic [MOD_WIDTH+1:0] m2;

  // one bit per cycle: r = (2r + bit*mult) mod m, with r and mult below m
  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, r, 1'b0} + (sh[OP_WIDTH-1] ? {2'b00, mult} : '0);
    if (t >= m2) begin
      r_next = MOD_WIDTH'(t - m2);
    end else if (t >= m1) begin
      r_next = MOD_WIDTH'(t - m1);
    end else begin
      r_next = MOD_WIDTH'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh   <= req.bits;
      mult <= req.mult;
      r    <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      r  <= r_next;
    end
  end

  assign result = r;

endmodule

// ----- hdl/modular_exponentiation_unit.sv -----
// Computes base_value ** exponent mod modulus by right-to-left square-and-multiply
// on one shared bit-serial multiply-reduce unit. A beat is taken only while the
// block is idle; the result beat follows after the unit has reduced the base,
// multiplied once for every set exponent bit and squared once for every bit
// below the highest set bit. The shared unit retires one multiplier bit per
// cycle. A modulus of zero or one answers 0 in the cycle after the input
// beat; an exponent of zero answers 1.
module modular_exponentiation_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mexp_pkg::BASE_IN_WIDTH-1:0]  base_value,
  input  logic [mexp_pkg::EXP_IN_WIDTH-1:0]   exponent,
  input  logic [mexp_pkg::MOD_IN_WIDTH-1:0]   modulus,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mexp_pkg::OUT_WIDTH-1:0]      power_mod
);
  import mexp_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [MOD_WIDTH-1:0] acc;
  logic [MOD_WIDTH-1:0] acc_next;
  logic [MOD_WIDTH-1:0] sq;
  logic [MOD_WIDTH-1:0] sq_next;
  logic [EXP_WIDTH-1:0] ex;
  logic [EXP_WIDTH-1:0] ex_next;
  logic [EXP_WIDTH-1:0] ex_sh;
  logic [MOD_WIDTH-1:0] m;
  logic [MOD_WIDTH-1:0] m_next;
  logic [MOD_WIDTH-1:0] m_in;
  mm_req_t              req;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_result;
  logic                 accept;

  assign m_in     = modulus[MOD_WIDTH-1:0];
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ex_sh    = ex >> 1;

  mexp_mulred u_mulred (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .modulus (m),
    .done    (mm_done),
    .result  (mm_result)
  );

  always_comb begin
    state_next = state;
    acc_next   = acc;
    sq_next    = sq;
    ex_next    = ex;
    m_next     = m;
    req.start  = 1'b0;
    req.mult   = acc;
    req.bits   = OP_WIDTH'(sq) << (OP_WIDTH - MOD_WIDTH);
    req.nbits  = CNT_WIDTH'(MOD_WIDTH);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          m_next  = m_in;
          ex_next = exponent[EXP_WIDTH-1:0];
          if (m_in[MOD_WIDTH-1:1] == '0) begin
            acc_next   = '0;
            state_next = ST_OUT;
          end else begin
            // base mod m as 1 * base through the shared unit
            acc_next   = MOD_WIDTH'(1);
            req.start  = 1'b1;
            req.mult   = MOD_WIDTH'(1);
            req.bits   = base_value;
            req.nbits  = CNT_WIDTH'(OP_WIDTH);
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mm_done) begin
          sq_next = mm_result;
          if (ex == '0) begin
            state_next = ST_OUT;
          end else if (ex[0]) begin
            req.start  = 1'b1;
            req.mult   = acc;
            req.bits   = OP_WIDTH'(mm_result) << (OP_WIDTH - MOD_WIDTH);
            state_next = ST_MUL;
          end else begin
            req.start  = 1'b1;
            req.mult   = mm_result;
            req.bits   = OP_WIDTH'(mm_result) << (OP_WIDTH - MOD_WIDTH);
            state_next = ST_SQR;
          end
        end
      end
      ST_MUL: begin
        if (mm_done) begin
          acc_next = mm_result;
          if (ex_sh == '0) begin
            state_next = ST_OUT;
          end else begin
            req.start  = 1'b1;
            req.mult   = sq;
            state_next = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          sq_next = mm_result;
          ex_next = ex_sh;
          if (ex_sh == '0) begin
            state_next = ST_OUT;
          end else if (ex_sh[0]) begin
            req.start  = 1'b1;
            req.mult   = acc;
            req.bits   = OP_WIDTH'(mm_result) << (OP_WIDTH - MOD_WIDTH);
            state_next = ST_MUL;
          end else begin
            req.start  = 1'b1;
            req.mult   = mm_result;
            req.bits   = OP_WIDTH'(mm_result) << (OP_WIDTH - MOD_WIDTH);
            state_next = ST_SQR;
          end
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (state_next == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    sq  <= sq_next;
    ex  <= ex_next;
    m   <= m_next;
    if (state != ST_OUT && state_next == ST_OUT) begin
      power_mod <= OUT_WIDTH'(acc_next);
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int BW = mexp_pkg::BASE_IN_WIDTH;
  localparam int EW = mexp_pkg::EXP_IN_WIDTH;
  localparam int MW = mexp_pkg::MOD_IN_WIDTH;
  localparam int OW = mexp_pkg::OUT_WIDTH;
  localparam int RANDOM_ITEMS = 110;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 200;

  class pow_scoreboard;
    bit [OW-1:0] expected_pow[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function bit [OW-1:0] predict_pow_mod(bit [BW-1:0] b, bit [EW-1:0] e, bit [MW-1:0] m);
      bit [63:0] acc;
      bit [63:0] sq;
      bit [63:0] mm;
      bit [63:0] ee;
      mm = {32'b0, m} & ((64'd1 << mexp_pkg::MOD_WIDTH) - 64'd1);
      ee = {1'b0, e} & ((64'd1 << mexp_pkg::EXP_WIDTH) - 64'd1);
      if (mm <= 64'd1) return '0;
      acc = 64'd1;
      sq = {1'b0, b} % mm;
      for (int i = 0; i < mexp_pkg::EXP_WIDTH; i++) begin
        if (ee[i]) acc = (acc * sq) % mm;
        sq = (sq * sq) % mm;
      end
      return acc[OW-1:0];
    endfunction

    function void note_request(bit [BW-1:0] b, bit [EW-1:0] e, bit [MW-1:0] m);
      expected_pow = {expected_pow, predict_pow_mod(b, e, m)};
    endfunction

    function void check_result(bit [OW-1:0] actual);
      bit [OW-1:0] want;
      if (expected_pow.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: power_mod=%0d", actual);
        return;
      end
      want = expected_pow.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10)
          $display("power_mod mismatch: expected %0d actual %0d", want, actual);
      end
    endfunction

    function int pending();
      return expected_pow.size();
    endfunction
  endclass

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_stall;
  logic [BW-1:0] base_value;
  logic [EW-1:0] exponent;
  logic [MW-1:0] modulus;
  logic          out_valid;
  logic          out_stall;
  logic [OW-1:0] power_mod;

  pow_scoreboard sb;
  int cycle_count;
  int stall_mode;
  int mode_timer;
  int stall_run;

  modular_exponentiation_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .base_value(base_value),
    .exponent(exponent),
    .modulus(modulus),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_mod(power_mod)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    sb = new();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(power_mod);
      if (mode_timer == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_timer = $urandom_range(50, 600);
      end else begin
        mode_timer = mode_timer - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 1) == 1);
        end
        default: begin
          if (stall_run > 0) begin
            stall_run = stall_run - 1;
            out_stall <= 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_run = $urandom_range(1, 30);
            out_stall <= 1'b1;
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  function automatic bit [BW-1:0] rand_wide();
    bit [63:0] w;
    w = {$urandom, $urandom};
    return w[BW-1:0];
  endfunction

  task automatic send_request(input bit [BW-1:0] b, input bit [EW-1:0] e, input bit [MW-1:0] m);
    in_valid <= 1'b1;
    base_value <= b;
    exponent <= e;
    modulus <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(b, e, m);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    bit [BW-1:0] b;
    bit [EW-1:0] e;
    bit [MW-1:0] m;
    bit [63:0] emask;
    int w;
    int pick;
    b = rand_wide();
    if ($urandom_range(0, 4) == 0) b = {{(BW-16){1'b0}}, b[15:0]};
    w = ($urandom_range(0, 2) == 0) ? $urandom_range(1, EW) : EW;
    emask = (64'd1 << w) - 64'd1;
    e = rand_wide() & emask[EW-1:0];
    pick = $urandom_range(0, 9);
    if (pick < 5) m = $urandom;
    else if (pick < 7) m = $urandom | 32'h8000_0000;
    else m = $urandom_range(2, 255);
    pick = $urandom_range(0, 19);
    if (pick == 0) m = 1;
    else if (pick == 1) e = '0;
    else if (pick == 2) b = BW'(m) * BW'($urandom_range(0, 1000));
    else if (pick == 3) b = BW'(m) - BW'(1);
    send_request(b, e, m);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    bit drained;
    rst = 1'b1;
    in_valid = 1'b0;
    base_value = '0;
    exponent = '0;
    modulus = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_request('0, '0, 32'd1);
    send_request('1, '1, 32'd1);
    send_request(63'd12345, '0, 32'd2);
    send_request('1, '0, 32'hFFFF_FFFF);
    send_request('0, 63'd5, 32'd7);
    send_request('1, '1, 32'hFFFF_FFFF);
    send_request('1, 63'd1, 32'hFFFF_FFFF);
    send_request(63'd2, 63'd10, 32'd1000);
    send_request('1, 63'd2, 32'hFFFF_FFFB);
    send_request(63'd7, 63'd3, 32'd0);
    send_request(63'd4294967291, 63'd3, 32'd4294967291);
    send_request(63'hFFFF_FFFE, '1, 32'hFFFF_FFFF);
    send_request(63'd3, 63'h4000_0000_0000_0000, 32'hFFFF_FFFB);
    send_request(63'd1, 63'd1, 32'd2);
    send_request(63'h4000_0000_0000_0000, 63'h5555_5555_5555_5555, 32'h8000_0000);
    send_request(63'h2AAA_AAAA_AAAA_AAAA, 63'h2AAA_AAAA_AAAA_AAAA, 32'd3);
    send_request(63'd65537, 63'd65537, 32'd2147483647);
    send_request('1, 63'd1, 32'd2);
    idle_cycles(3);
    send_request(63'd10, 63'd1, 32'd3);

    sent = 0;
    drained = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_random_request();
        sent++;
      end
      if (!drained && sent >= RANDOM_ITEMS / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      gap = $urandom_range(0, 9);
      if (gap < 3) gap = 0;
      else if (gap == 9) gap = $urandom_range(100, 3000);
      else gap = $urandom_range(1, 40);
      idle_cycles(gap);
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- modular_exponentiation_unit.f -----
hdl/mexp_pkg.sv
hdl/mexp_mulred.sv
hdl/modular_exponentiation_unit.sv
verif/tb_top.sv
